FILE: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Command and status codes shared by the double-ended queue unit and its
// checker.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DataW = 32;

  typedef enum logic [2:0] {
    CMD_ADD_FRONT = 3'd0,
    CMD_ADD_REAR  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_REAR  = 3'd3,
    CMD_DUMP      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DATA       = 2'd0,
    ST_UNDERFLOW  = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_DUMP_EMPTY = 2'd3
  } status_e;

endpackage

FILE: rtl/core/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Entry store of the queue ring: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic signed [dq_pkg::DataW-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic signed [dq_pkg::DataW-1:0] rdata_o
);

  logic signed [dq_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [dq_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Command sequencer of the queue: head and fill tracking, memory access
// and the output register.
// ----------------------------------------------------------------------------
module dq_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      command_i,
  input  logic signed [dq_pkg::DataW-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic signed [dq_pkg::DataW-1:0] data_o,
  output logic                            last_o,
  output logic                            ram_we_o,
  output logic [AW-1:0]                   ram_waddr_o,
  output logic signed [dq_pkg::DataW-1:0] ram_wdata_o,
  output logic                            ram_re_o,
  output logic [AW-1:0]                   ram_raddr_o,
  input  logic signed [dq_pkg::DataW-1:0] ram_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DUMP,
    S_RESP
  } state_e;

  localparam logic [CW:0]   DepthWide = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] DepthCnt  = CW'(DEPTH);
  localparam logic [AW-1:0] LastSlot  = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] slot_f(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= DepthWide) begin
      sum = sum - DepthWide;
    end
    return sum[AW-1:0];
  endfunction

  state_e                          state_q, state_d;
  logic [AW-1:0]                   head_q, head_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [1:0]                      res_status_q, res_status_d;
  logic                            out_valid_q, out_valid_d;
  logic [1:0]                      out_status_q, out_status_d;
  logic signed [dq_pkg::DataW-1:0] out_data_q, out_data_d;
  logic                            out_last_q, out_last_d;
  logic                            out_free;
  logic                            full;
  logic                            empty;
  logic [AW-1:0]                   head_m1;

  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (count_q == DepthCnt);
  assign empty    = (count_q == '0);
  assign head_m1  = (head_q == '0) ? LastSlot : head_q - 1'b1;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    in_ready_o   = (state_q == S_IDLE);
    ram_we_o     = 1'b0;
    ram_waddr_o  = head_q;
    ram_wdata_o  = value_i;
    ram_re_o     = 1'b0;
    ram_raddr_o  = head_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            dq_pkg::CMD_ADD_FRONT, dq_pkg::CMD_ADD_REAR: begin
              if (full) begin
                res_status_d = dq_pkg::ST_OVERFLOW;
                state_d      = S_RESP;
              end else begin
                ram_we_o = 1'b1;
                if (command_i == dq_pkg::CMD_ADD_FRONT) begin
                  ram_waddr_o = head_m1;
                  head_d      = head_m1;
                end else begin
                  ram_waddr_o = slot_f(head_q, count_q);
                end
                count_d = count_q + 1'b1;
              end
            end
            dq_pkg::CMD_REM_FRONT, dq_pkg::CMD_REM_REAR: begin
              if (empty) begin
                res_status_d = dq_pkg::ST_UNDERFLOW;
                state_d      = S_RESP;
              end else begin
                ram_re_o = 1'b1;
                if (command_i == dq_pkg::CMD_REM_FRONT) begin
                  ram_raddr_o = head_q;
                  head_d      = slot_f(head_q, CW'(1));
                end else begin
                  ram_raddr_o = slot_f(head_q, count_q - 1'b1);
                end
                count_d = count_q - 1'b1;
                state_d = S_READ;
              end
            end
            dq_pkg::CMD_DUMP: begin
              if (empty) begin
                res_status_d = dq_pkg::ST_DUMP_EMPTY;
                state_d      = S_RESP;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = head_q;
                idx_d       = CW'(1);
                state_d     = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = dq_pkg::ST_DATA;
          out_data_d   = ram_rdata_i;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = dq_pkg::ST_DATA;
          out_data_d   = ram_rdata_i;
          out_last_d   = (idx_q == count_q);
          if (idx_q == count_q) begin
            state_d = S_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = slot_f(head_q, idx_q);
            idx_d       = idx_q + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      res_status_q <= dq_pkg::ST_DATA;
      out_valid_q  <= 1'b0;
      out_status_q <= dq_pkg::ST_DATA;
      out_data_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_o      = out_data_q;
  assign last_o      = out_last_q;

endmodule

FILE: rtl/core/double_ended_queue_unit.sv
// An add is written to the entry memory on acceptance and the unit stays ready
// for the next command; a removal or status beat goes through S_READ or S_RESP
// into the output register. A dump streams one entry per cycle, while the output
// is not stalled, from the entry memory's single read port; the next command is
// accepted once the final beat is loaded. Reset clears head, fill count and
// control state; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of signed 32-bit words kept in a ring memory with a head
// index and a fill count.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      command_i,
  input  logic signed [dq_pkg::DataW-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic signed [dq_pkg::DataW-1:0] data_o,
  output logic                            last_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic signed [dq_pkg::DataW-1:0] ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic signed [dq_pkg::DataW-1:0] ram_rdata;

  dq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_dq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_dq_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .last_o      (last_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

FILE: rtl/core/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the double-ended queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [2:0]                      command_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      status_o,
  input logic signed [dq_pkg::DataW-1:0] data_o,
  input logic                            last_o
);

  logic in_beat;

  assign in_beat = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(data_o)
      && $stable(last_o))
    else $error("output beat changed while stalled");

  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != dq_pkg::ST_DATA) |-> last_o && (data_o == '0))
    else $error("status beat without last or with nonzero data");

  a_busy_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && ((command_i == dq_pkg::CMD_REM_FRONT) || (command_i == dq_pkg::CMD_REM_REAR)
      || (command_i == dq_pkg::CMD_DUMP)) |=> !in_ready_o)
    else $error("command accepted while removal or dump in progress");

  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("command accepted in the middle of a dump");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);
